### hdl/int2p_pkg.sv
package int2p_pkg;

	localparam int WORD_BITS = 32;
	localparam int RADIX_MAX = 5;
	localparam int DIGIT_BITS = 5;
	localparam logic [7:0] BUF_RESET = 8'd34;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_ALPHA = 8'h41;
	localparam logic [7:0] CHAR_NONE = 8'h00;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_BASE  = 2'd1,
		ST_BUF_SMALL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_DIGIT
	} conv_state_t;

	// 0-9 then A-V
	function automatic logic [7:0] digit_glyph(input logic [DIGIT_BITS-1:0] d);
		logic [7:0] ch;
		if (d < 5'd10) begin
			ch = CHAR_ZERO + {3'b000, d};
		end else begin
			ch = CHAR_ALPHA + {3'b000, d} - 8'd10;
		end
		return ch;
	endfunction

endpackage

### hdl/int2p_in_if.sv
interface int2p_in_if import int2p_pkg::*; #(
	parameter int WordBits = WORD_BITS
) ();
	logic                       valid;
	logic                       ready;
	logic signed [WordBits-1:0] value;
	logic [2:0]                 radix_bits;

	modport source (output valid, output value, output radix_bits, input ready);
	modport sink (input valid, input value, input radix_bits, output ready);
endinterface

### hdl/int2p_out_if.sv
interface int2p_out_if import int2p_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] char_out;
	logic [1:0] status;
	logic       last;

	modport source (output valid, output char_out, output status, output last, input ready);
	modport sink (input valid, input char_out, input status, input last, output ready);
endinterface

### hdl/int2p_digit_sr.sv
module int2p_digit_sr import int2p_pkg::*; #(
	parameter int WordBits = WORD_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  logic                  advance,
	input  logic [WordBits-1:0]   mag,
	input  logic [2:0]            radix,
	output logic [DIGIT_BITS-1:0] digit,
	output logic                  last_digit
);
	localparam int SrBits = WordBits + DIGIT_BITS - 1;
	localparam int CntBits = $clog2(WordBits + 1);
	localparam int Nd1 = WordBits;
	localparam int Nd2 = (WordBits + 1) / 2;
	localparam int Nd3 = (WordBits + 2) / 3;
	localparam int Nd4 = (WordBits + 3) / 4;
	localparam int Nd5 = (WordBits + 4) / 5;
	localparam int Pad2 = Nd2 * 2 - WordBits;
	localparam int Pad3 = Nd3 * 3 - WordBits;
	localparam int Pad4 = Nd4 * 4 - WordBits;
	localparam int Pad5 = Nd5 * 5 - WordBits;

	logic [SrBits-1:0]     sr_q;
	logic [CntBits-1:0]    cnt_q;
	logic [2:0]            radix_q;
	logic [CntBits-1:0]    nd;
	logic [2:0]            pad;
	logic [DIGIT_BITS-1:0] top;

	// digit count and zero padding above the msb for each radix
	always_comb begin
		unique case (radix)
			3'd2: begin
				nd  = CntBits'(Nd2);
				pad = 3'(Pad2);
			end
			3'd3: begin
				nd  = CntBits'(Nd3);
				pad = 3'(Pad3);
			end
			3'd4: begin
				nd  = CntBits'(Nd4);
				pad = 3'(Pad4);
			end
			3'd5: begin
				nd  = CntBits'(Nd5);
				pad = 3'(Pad5);
			end
			default: begin
				nd  = CntBits'(Nd1);
				pad = 3'd0;
			end
		endcase
	end

	assign top        = sr_q[SrBits-1 -: DIGIT_BITS];
	assign digit      = top >> (3'(DIGIT_BITS) - radix_q);
	assign last_digit = (cnt_q == CntBits'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			radix_q <= 3'd1;
		end else if (load) begin
			cnt_q   <= nd;
			radix_q <= radix;
		end else if (advance) begin
			cnt_q <= cnt_q - CntBits'(1);
		end
	end

	// magnitude aligned so the first digit sits in the top bits
	always_ff @(posedge clk) begin
		if (load) begin
			sr_q <= SrBits'(mag) << (3'(DIGIT_BITS - 1) - pad);
		end else if (advance) begin
			sr_q <= sr_q << radix_q;
		end
	end
endmodule

### hdl/int_to_pow2_base_ascii.sv
// int_to_pow2_base_ascii: signed integer to ascii text in base 2^r, msd first
// sequence: the load state emits a minus sign, or a zero or error result that ends the item;
// the digit state then drops leading zero digits without a transfer and emits the rest
// throughput: one character per cycle unless the sink stalls or a leading zero is skipped,
// set by the digit shift register stepping r bits; a new item waits for the idle state
// reset: arst_n clears control and returns buffer_size to 34; no clearing pass
module int_to_pow2_base_ascii import int2p_pkg::*; #(
	parameter int WordBits = WORD_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	int2p_in_if.sink    in_ch,
	int2p_out_if.source out_ch
);
	localparam logic [7:0] MinBuf = 8'(WordBits + 2);

	conv_state_t state_q, state_nxt;

	// configuration
	logic [7:0] buf_size_q;

	// captured input item
	logic [WordBits-1:0] value_q;
	logic [2:0]          radix_q;

	// output register, parts the converter from the sink
	logic       out_valid_q;
	logic [7:0] char_q;
	status_t    status_q;
	logic       last_q;

	logic                  started_q;
	logic                  slot_free;
	logic                  neg;
	logic [WordBits-1:0]   mag;
	logic                  bad_base;
	logic                  buf_small;
	logic                  mag_zero;
	logic                  single_result;
	logic [DIGIT_BITS-1:0] digit;
	logic                  last_digit;
	logic                  skip;
	logic                  sr_load;
	logic                  sr_advance;
	logic                  emit;
	logic [7:0]            emit_char;
	status_t               emit_status;
	logic                  emit_last;

	assign in_ch.ready     = (state_q == S_IDLE);
	assign out_ch.valid    = out_valid_q;
	assign out_ch.char_out = char_q;
	assign out_ch.status   = status_q;
	assign out_ch.last     = last_q;

	// output register can take a character this cycle
	assign slot_free = !out_valid_q || out_ch.ready;

	// sign and magnitude; the most negative value wraps to its exact magnitude
	assign neg       = value_q[WordBits-1];
	assign mag       = neg ? (~value_q + WordBits'(1)) : value_q;
	assign mag_zero  = (mag == '0);
	assign bad_base  = (radix_q == 3'd0) || (radix_q > 3'(RADIX_MAX));
	assign buf_small = (buf_size_q < MinBuf);

	// error results and zero each give one character only
	assign single_result = bad_base || buf_small || mag_zero;

	// leading zero digits are dropped without a transfer
	assign skip = (digit == '0) && !started_q && !last_digit;

	int2p_digit_sr #(
		.WordBits(WordBits)
	) u_digit_sr (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (sr_load),
		.advance   (sr_advance),
		.mag       (mag),
		.radix     (radix_q),
		.digit     (digit),
		.last_digit(last_digit)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_ch.valid) begin
					state_nxt = S_LOAD;
				end
			end
			S_LOAD: begin
				if (slot_free) begin
					state_nxt = single_result ? S_IDLE : S_DIGIT;
				end
			end
			S_DIGIT: begin
				if (!skip && slot_free && last_digit) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		sr_load     = 1'b0;
		sr_advance  = 1'b0;
		emit        = 1'b0;
		emit_char   = CHAR_NONE;
		emit_status = ST_OK;
		emit_last   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
			end
			S_LOAD: begin
				sr_load = slot_free;
				if (bad_base) begin
					emit        = slot_free;
					emit_status = ST_BAD_BASE;
					emit_last   = 1'b1;
				end else if (buf_small) begin
					emit        = slot_free;
					emit_status = ST_BUF_SMALL;
					emit_last   = 1'b1;
				end else if (mag_zero) begin
					emit      = slot_free;
					emit_char = CHAR_ZERO;
					emit_last = 1'b1;
				end else if (neg) begin
					emit      = slot_free;
					emit_char = CHAR_MINUS;
				end
			end
			S_DIGIT: begin
				sr_advance = skip || slot_free;
				emit       = !skip && slot_free;
				emit_char  = digit_glyph(digit);
				emit_last  = last_digit;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			buf_size_q  <= BUF_RESET;
			out_valid_q <= 1'b0;
			started_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				buf_size_q <= cfg_wdata;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (sr_load) begin
				started_q <= 1'b0;
			end else if (state_q == S_DIGIT && emit) begin
				started_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			value_q <= in_ch.value;
			radix_q <= in_ch.radix_bits;
		end
		if (emit) begin
			char_q   <= emit_char;
			status_q <= emit_status;
			last_q   <= emit_last;
		end
	end
endmodule
